FILE: rtl/core/sss_pkg.sv
// Shared types and constants for the selection sort and search block.
// No dependencies; every other file of the block but sss_ram imports this package.
`default_nettype none

package sss_pkg;

  // Vector geometry.
  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths of the item interfaces.
  localparam int VAL_W  = 32;
  localparam int OIDX_W = 6;
  localparam int REQ_W  = 2;

  // Request codes; the fourth code is ignored.
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SORT   = 2'd1,
    REQ_SEARCH = 2'd2
  } req_t;

  // Result of the shared compare unit.
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

  // One cycle's access to the element memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/sss_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on sss_pkg for field widths.
`default_nettype none

interface sss_in_if;
  import sss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic                    start_new;
  logic signed [VAL_W-1:0] elem_value;
  logic signed [VAL_W-1:0] search_value;

  modport source (output valid, req_type, start_new, elem_value, search_value,
                  input ready);
  modport sink   (input valid, req_type, start_new, elem_value, search_value,
                  output ready);
endinterface

interface sss_out_if;
  import sss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_value;
  logic [OIDX_W-1:0]       out_index;
  logic                    found;
  logic                    last;

  modport source (output valid, out_value, out_index, found, last, input ready);
  modport sink   (input valid, out_value, out_index, found, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sss_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`default_nettype none

module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sss_cmp.sv
// Shared signed compare unit used by the sort passes and the search scans.
// Depends on sss_pkg.
`default_nettype none

module sss_cmp (
  input  wire logic [sss_pkg::VAL_W-1:0] a,
  input  wire logic [sss_pkg::VAL_W-1:0] b,
  output sss_pkg::cmp_res_t              res
);
  import sss_pkg::*;

  // Two's complement greater-than and bitwise equality.
  always_comb begin
    res.gt = $signed(a) > $signed(b);
    res.eq = (a == b);
  end

endmodule

`default_nettype wire

FILE: rtl/core/sss_seq.sv
// Sequencer: element count, sort passes, search scans and the result register.
// Depends on sss_pkg; drives the element memory and reads the compare unit.
`default_nettype none

module sss_seq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Request items.
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [sss_pkg::REQ_W-1:0] in_req_type,
  input  wire logic                      in_start_new,
  input  wire logic [sss_pkg::VAL_W-1:0] in_elem_value,
  input  wire logic [sss_pkg::VAL_W-1:0] in_search_value,
  // Result items.
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [sss_pkg::VAL_W-1:0]      out_value,
  output logic [sss_pkg::OIDX_W-1:0]     out_index,
  output logic                           out_found,
  output logic                           out_last,
  // Element memory and compare unit.
  output sss_pkg::mem_req_t              mem_req,
  input  wire logic [sss_pkg::VAL_W-1:0] mem_rdata,
  output logic [sss_pkg::VAL_W-1:0]      cmp_a,
  output logic [sss_pkg::VAL_W-1:0]      cmp_b,
  input  wire sss_pkg::cmp_res_t         cmp_res
);
  import sss_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_SCAN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_EMIT_RD,
    ST_EMIT_WT,
    ST_MISS
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             sort_r, sort_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] addr_q_r, addr_q_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic [VAL_W-1:0] best_val_r, best_val_nxt;
  logic [VAL_W-1:0] ival_r, ival_nxt;
  logic [VAL_W-1:0] sv_r, sv_nxt;
  logic             any_r, any_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic [OIDX_W-1:0] out_index_r, out_index_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_last_r, out_last_nxt;

  logic             accept;
  logic             slot_free;
  logic [IDX_W-1:0] lastpos;
  logic             scan_hit;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign lastpos   = IDX_W'(count_r - CNT_W'(1));
  assign scan_hit  = !sort_r && cmp_res.eq;

  // The compare unit always sees the freshly read element against either the
  // running maximum (sort) or the latched search value (search).
  assign cmp_a = mem_rdata;
  assign cmp_b = sort_r ? best_val_r : sv_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_index = out_index_r;
  assign out_found = out_found_r;
  assign out_last  = out_last_r;

  // Next-state logic for the sequencer, memory port and result register.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sort_nxt      = sort_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    addr_q_nxt    = addr_q_r;
    best_nxt      = best_r;
    best_val_nxt  = best_val_r;
    ival_nxt      = ival_r;
    sv_nxt        = sv_r;
    any_nxt       = any_r;
    hit_nxt       = hit_r;
    k_nxt         = k_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    mem_req       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_LOAD: begin
              // Append, restarting the vector first when asked; drop when full.
              if (in_start_new) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                mem_req.wdata = in_elem_value;
                count_nxt     = CNT_W'(1);
              end else if (count_r < CNT_W'(DEPTH)) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = IDX_W'(count_r);
                mem_req.wdata = in_elem_value;
                count_nxt     = count_r + CNT_W'(1);
              end
            end
            REQ_SORT: begin
              sort_nxt = 1'b1;
              i_nxt    = '0;
              k_nxt    = '0;
              end_nxt  = lastpos;
              if (count_r >= CNT_W'(2)) begin
                state_nxt = ST_PASS;
              end else if (count_r == CNT_W'(1)) begin
                state_nxt = ST_EMIT_RD;
              end
            end
            REQ_SEARCH: begin
              sort_nxt = 1'b0;
              sv_nxt   = in_search_value;
              i_nxt    = '0;
              any_nxt  = 1'b0;
              state_nxt = (count_r == '0) ? ST_MISS : ST_PASS;
            end
            default: begin
            end
          endcase
        end
      end

      ST_PASS: begin
        // Open a scan at position i.
        mem_req.re    = 1'b1;
        mem_req.raddr = i_r;
        addr_q_nxt    = i_r;
        j_nxt         = CNT_W'(i_r) + CNT_W'(1);
        state_nxt     = ST_SCAN;
      end

      ST_SCAN: begin
        // Issue the next read while the previous element is compared.
        if (j_r < count_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = IDX_W'(j_r);
          addr_q_nxt    = IDX_W'(j_r);
          j_nxt         = j_r + CNT_W'(1);
        end
        if (sort_r) begin
          if (addr_q_r == i_r) begin
            best_val_nxt = mem_rdata;
            best_nxt     = i_r;
            ival_nxt     = mem_rdata;
          end else if (cmp_res.gt) begin
            best_val_nxt = mem_rdata;
            best_nxt     = addr_q_r;
          end
        end else if (scan_hit) begin
          any_nxt = 1'b1;
          hit_nxt = addr_q_r;
        end
        if (addr_q_r == lastpos) begin
          if (sort_r) begin
            state_nxt = ST_SWAP_A;
          end else if (any_r || scan_hit) begin
            k_nxt     = '0;
            end_nxt   = scan_hit ? addr_q_r : hit_r;
            state_nxt = ST_EMIT_RD;
          end else begin
            state_nxt = ST_MISS;
          end
        end
      end

      ST_SWAP_A: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r;
        mem_req.wdata = best_val_r;
        state_nxt     = ST_SWAP_B;
      end

      ST_SWAP_B: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = best_r;
        mem_req.wdata = ival_r;
        i_nxt         = i_r + IDX_W'(1);
        state_nxt     = (CNT_W'(i_r) + CNT_W'(2) < count_r) ? ST_PASS : ST_EMIT_RD;
      end

      ST_EMIT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = k_r;
        state_nxt     = ST_EMIT_WT;
      end

      ST_EMIT_WT: begin
        // Sort emits every element; search emits the matching ones only.
        if (!(sort_r || cmp_res.eq) || slot_free) begin
          if (sort_r || cmp_res.eq) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = mem_rdata;
            out_index_nxt = OIDX_W'(k_r);
            out_found_nxt = !sort_r;
            out_last_nxt  = (k_r == end_r);
          end
          if (k_r == end_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      ST_MISS: begin
        // Single not-found result.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_index_nxt = '0;
          out_found_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sort_r      <= sort_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    addr_q_r    <= addr_q_nxt;
    best_r      <= best_nxt;
    best_val_r  <= best_val_nxt;
    ival_r      <= ival_nxt;
    sv_r        <= sv_nxt;
    any_r       <= any_nxt;
    hit_r       <= hit_nxt;
    k_r         <= k_nxt;
    end_r       <= end_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/selection_sort_and_search.sv
// Top level of the selection sort and search block.
// Depends on sss_pkg, sss_if, sss_ram, sss_cmp and sss_seq.
//
//   Channel  Direction  Handshake     Payload
//   in_ch    input      valid/ready   req_type, start_new, elem_value, search_value
//   out_ch   output     valid/ready   out_value, out_index, found, last
//
// A load writes its element from the idle state. A sort of n elements runs, for
// each pass i from 0 to n-2, an open, a scan and two swap writes, then reads
// out each result; the single memory read port and the shared comparator set
// this order. A search scans all n elements, then reads each element in turn
// up to the last match; a miss gives one result. Reset clears the state, count
// and result valid only; the element memory is not cleared. in_ch is ready
// only between requests; a stalled out_ch holds the sequencer at its next result.
`default_nettype none

module selection_sort_and_search (
  input  wire logic clk,
  input  wire logic rst_n,
  sss_in_if.sink    in_ch,
  sss_out_if.source out_ch
);
  import sss_pkg::*;

  mem_req_t         mem_req;
  logic [VAL_W-1:0] mem_rdata;
  logic [VAL_W-1:0] cmp_a;
  logic [VAL_W-1:0] cmp_b;
  cmp_res_t         cmp_res;
  logic [VAL_W-1:0] out_value_w;

  assign out_ch.out_value = $signed(out_value_w);

  // Sequencer with the result register.
  sss_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_req_type     (in_ch.req_type),
    .in_start_new    (in_ch.start_new),
    .in_elem_value   (in_ch.elem_value),
    .in_search_value (in_ch.search_value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_value       (out_value_w),
    .out_index       (out_ch.out_index),
    .out_found       (out_ch.found),
    .out_last        (out_ch.last),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata),
    .cmp_a           (cmp_a),
    .cmp_b           (cmp_b),
    .cmp_res         (cmp_res)
  );

  // Shared comparator.
  sss_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // Element storage.
  sss_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: dv/tb_selection_sort_and_search.sv
`timescale 1ns / 1ps
// Self-checking testbench for the selection sort and search block.
// Depends on sss_pkg, the sss_in_if and sss_out_if interfaces, and the block's RTL.

module tb_selection_sort_and_search;
  import sss_pkg::*;

  // Request code that the block ignores.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Marks a stimulus row whose results come from the shadow model.
  localparam int PREDICT = -1;

  localparam int TOTAL_ITEMS = 410;
  localparam int TAIL_CYCLES = 800;
  localparam int CYCLE_LIMIT = 2_000_000;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic [REQ_W-1:0]        req;
    logic                    start;
    logic signed [VAL_W-1:0] ev;
    logic signed [VAL_W-1:0] sv;
  } req_item_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [OIDX_W-1:0]       index;
    logic                    found;
    logic                    last;
  } result_t;

  typedef struct {
    req_item_t item;
    int        n_typed;
    result_t   typed;
  } dir_row_t;

  localparam result_t NO_RESULT = '{value: '0, index: '0, found: 1'b0, last: 1'b0};
  localparam result_t MISS      = '{value: '0, index: '0, found: 1'b0, last: 1'b1};

  logic clk;
  logic rst_n;

  sss_in_if  in_ch ();
  sss_out_if out_ch ();

  selection_sort_and_search uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the vector and its fill level.
  logic signed [VAL_W-1:0] shadow_elems [DEPTH];
  int                      shadow_count;

  // Results computed for the latest request, and results still owed by the block.
  result_t new_results [$];
  result_t owed_results [$];

  dir_row_t dir_tab [$];

  int  errors;
  int  items_sent;
  int  results_seen;
  int  n_sorts;
  int  n_searches;
  int  n_hits;
  int  n_drops;
  bit  no_idle;
  bit  drain_first;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run guard.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Shadow model: updates the vector and fills new_results for one request.
  task automatic predict_request(input req_item_t it);
    int                      n;
    int                      best;
    int                      hit_last;
    bit                      any;
    logic signed [VAL_W-1:0] t;
    result_t                 r;
    new_results.delete();
    n = shadow_count;
    case (it.req)
      REQ_LOAD: begin
        if (it.start) n = 0;
        if (n < DEPTH) begin
          shadow_elems[n] = it.ev;
          n++;
        end else begin
          n_drops++;
        end
        shadow_count = n;
      end
      REQ_SORT: begin
        n_sorts++;
        for (int i = 0; i + 1 < n; i++) begin
          best = i;
          for (int j = i + 1; j < n; j++) begin
            if (shadow_elems[j] > shadow_elems[best]) best = j;
          end
          if (best != i) begin
            t = shadow_elems[i];
            shadow_elems[i] = shadow_elems[best];
            shadow_elems[best] = t;
          end
        end
        for (int i = 0; i < n; i++) begin
          r.value = shadow_elems[i];
          r.index = i[OIDX_W-1:0];
          r.found = 1'b0;
          r.last  = (i + 1 == n);
          new_results.push_back(r);
        end
      end
      REQ_SEARCH: begin
        n_searches++;
        any = 1'b0;
        hit_last = 0;
        for (int i = 0; i < n; i++) begin
          if (shadow_elems[i] === it.sv) begin
            any = 1'b1;
            hit_last = i;
          end
        end
        if (!any) begin
          new_results.push_back(MISS);
        end else begin
          for (int i = 0; i < n; i++) begin
            if (shadow_elems[i] === it.sv) begin
              n_hits++;
              r.value = shadow_elems[i];
              r.index = i[OIDX_W-1:0];
              r.found = 1'b1;
              r.last  = (i == hit_last);
              new_results.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Drives one request item and books the results it owes.
  task automatic send_item(input req_item_t it, input int n_typed, input result_t typed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (drain_first) begin
      // Hold off until the block has delivered everything it owes.
      drain_first = 1'b0;
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (owed_results.size() != 0);
    end else if (gap > 0) begin
      in_ch.valid <= 1'b0;
    end
    repeat (gap) @(posedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= it.req;
    in_ch.start_new    <= it.start;
    in_ch.elem_value   <= it.ev;
    in_ch.search_value <= it.sv;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_request(it);
    if (n_typed == PREDICT) begin
      foreach (new_results[i]) owed_results.push_back(new_results[i]);
    end else if (n_typed == 1) begin
      owed_results.push_back(typed);
    end
    items_sent++;
  endtask

  // Mostly extremes and a small pool of values, so that duplicates are common.
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = VAL_MAX;
      1:       v = VAL_MIN;
      2:       v = '0;
      3:       v = -1;
      4, 5, 6: v = ($signed($urandom_range(0, 7)) - 4) <<< 16;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Usually a value that is stored, so that searches find matches.
  function automatic logic signed [VAL_W-1:0] search_target();
    if (shadow_count > 0 && $urandom_range(0, 2) != 0)
      return shadow_elems[$urandom_range(0, shadow_count - 1)];
    return pick_value();
  endfunction

  task automatic send_query(input logic [REQ_W-1:0] req);
    req_item_t it;
    it.req   = req;
    it.start = 1'($urandom_range(0, 1));
    it.ev    = $urandom;
    it.sv    = search_target();
    send_item(it, PREDICT, NO_RESULT);
  endtask

  task automatic send_load(input logic start);
    req_item_t it;
    it.req   = REQ_LOAD;
    it.start = start;
    it.ev    = pick_value();
    it.sv    = $urandom;
    send_item(it, PREDICT, NO_RESULT);
  endtask

  task automatic add_row(input logic [REQ_W-1:0] req, input logic start,
                         input logic signed [VAL_W-1:0] ev, input logic signed [VAL_W-1:0] sv,
                         input int n_typed, input result_t typed);
    dir_row_t row;
    row.item.req   = req;
    row.item.start = start;
    row.item.ev    = ev;
    row.item.sv    = sv;
    row.n_typed    = n_typed;
    row.typed      = typed;
    dir_tab.push_back(row);
  endtask

  // Result side: random back-pressure, and each result checked against the oldest one owed.
  initial begin : result_sink
    int      stall;
    result_t want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      results_seen++;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h index=%0d found=%b last=%b", $time,
                 out_ch.out_value, out_ch.out_index, out_ch.found, out_ch.last);
      end else begin
        want = owed_results.pop_front();
        if (out_ch.out_value !== want.value || out_ch.out_index !== want.index ||
            out_ch.found !== want.found || out_ch.last !== want.last) begin
          errors++;
          $display("%0t: mismatch expected value=%h index=%0d found=%b last=%b", $time,
                   want.value, want.index, want.found, want.last);
          $display("%0t:          actual   value=%h index=%0d found=%b last=%b", $time,
                   out_ch.out_value, out_ch.out_index, out_ch.found, out_ch.last);
        end
      end
    end
  end

  // Request side: reset, directed table, random sequences, then drain.
  initial begin : request_source
    req_item_t it;
    int        kind;
    int        len;
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    n_sorts      = 0;
    n_searches   = 0;
    n_hits       = 0;
    n_drops      = 0;
    no_idle      = 1'b0;
    drain_first  = 1'b0;
    shadow_count = 0;
    foreach (shadow_elems[i]) shadow_elems[i] = '0;

    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= REQ_LOAD;
    in_ch.start_new    <= 1'b0;
    in_ch.elem_value   <= '0;
    in_ch.search_value <= '0;
    rst_n              <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty vector, extremes, duplicates, ignored code and stray start flags.
    add_row(REQ_SEARCH, 1'b0, '0,        '0,        1, MISS);
    add_row(REQ_SORT,   1'b0, '0,        '0,        0, NO_RESULT);
    add_row(REQ_UNUSED, 1'b0, '0,        '0,        0, NO_RESULT);
    add_row(REQ_LOAD,   1'b1, VAL_MAX,   '0,        0, NO_RESULT);
    add_row(REQ_SEARCH, 1'b0, '0,        VAL_MAX,   1,
            '{value: VAL_MAX, index: '0, found: 1'b1, last: 1'b1});
    add_row(REQ_SEARCH, 1'b0, '0,        VAL_MIN,   1, MISS);
    add_row(REQ_LOAD,   1'b0, VAL_MIN,   '0,        0, NO_RESULT);
    add_row(REQ_LOAD,   1'b0, '0,        '0,        0, NO_RESULT);
    add_row(REQ_LOAD,   1'b0, -1,        '0,        0, NO_RESULT);
    add_row(REQ_LOAD,   1'b0, 1,         '0,        0, NO_RESULT);
    add_row(REQ_LOAD,   1'b0, VAL_MAX,   '0,        0, NO_RESULT);
    add_row(REQ_SEARCH, 1'b0, '0,        VAL_MAX,   PREDICT, NO_RESULT);
    add_row(REQ_SORT,   1'b0, '0,        '0,        PREDICT, NO_RESULT);
    add_row(REQ_SEARCH, 1'b0, '0,        VAL_MAX,   PREDICT, NO_RESULT);
    add_row(REQ_SEARCH, 1'b0, '0,        '0,        PREDICT, NO_RESULT);
    add_row(REQ_UNUSED, 1'b1, -1,        -1,        0, NO_RESULT);
    add_row(REQ_SORT,   1'b1, -1,        -1,        PREDICT, NO_RESULT);
    add_row(REQ_SEARCH, 1'b0, '0,        32'sh1234_5678, 1, MISS);
    add_row(REQ_LOAD,   1'b1, 32'sh5555_5555, '0,   0, NO_RESULT);
    add_row(REQ_SORT,   1'b0, '0,        '0,        1,
            '{value: 32'sh5555_5555, index: '0, found: 1'b0, last: 1'b1});
    add_row(REQ_LOAD,   1'b1, 32'shAAAA_AAAA, '0,   0, NO_RESULT);
    add_row(REQ_LOAD,   1'b0, 32'shAAAA_AAAA, '0,   0, NO_RESULT);
    add_row(REQ_SEARCH, 1'b0, '0,        32'shAAAA_AAAA, PREDICT, NO_RESULT);
    add_row(REQ_SEARCH, 1'b1, -1,        32'sh5555_5555, 1, MISS);

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].n_typed, dir_tab[i].typed);

    // Random part: mostly load-then-query sequences, some overfilling the vector.
    drain_first = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 4)
                                          : $urandom_range(1, 8);
        send_load(1'b1);
        for (int k = 1; k < len; k++) send_load(1'b0);
        repeat ($urandom_range(0, 2)) send_query(REQ_SEARCH);
        if ($urandom_range(0, 9) != 0) send_query(REQ_SORT);
        repeat ($urandom_range(1, 3)) send_query(REQ_SEARCH);
      end else if (kind == 7) begin
        // Noise with every field random, the ignored code included.
        it.req   = REQ_W'($urandom_range(0, 3));
        it.start = 1'($urandom_range(0, 1));
        it.ev    = $urandom;
        it.sv    = $urandom;
        send_item(it, PREDICT, NO_RESULT);
      end else if (kind == 8) begin
        // Append to whatever is stored, then sort again.
        repeat ($urandom_range(1, 3)) send_load(1'b0);
        send_query(REQ_SORT);
      end else begin
        drain_first = 1'b1;
        no_idle     = ($urandom_range(0, 2) == 0);
      end
    end
    in_ch.valid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d sorts, %0d searches with %0d matches, %0d loads dropped.",
             items_sent, n_sorts, n_searches, n_hits, n_drops);
    $display("Checked %0d results, %0d errors.", results_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
